// ===== sv/spmb_pkg.sv =====
package spmb_pkg;

    // Field widths of the input and output beats.
    localparam int OPCODE_W = 2;
    localparam int POS_W    = 11;
    localparam int SAMPLE_W = 32;
    localparam int BYTE_W   = 8;
    localparam int PCM_W    = 2 * BYTE_W;

    // Default depth of the mix store.
    localparam int unsigned BUFFER_SAMPLES_DEF = 2048;

    // Width that can hold any depth up to the largest supported store.
    localparam int DEPTH_CMP_W = 17;

    // Opcodes.
    localparam logic [OPCODE_W-1:0] OP_WRITE      = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ADD        = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_ADD_EMIT   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_WRITE_EMIT = 2'd3;

    // Symmetric clamp limits of the 16-bit output sample.
    localparam logic signed [SAMPLE_W-1:0] CLAMP_HIGH = 32'sd32767;
    localparam logic signed [SAMPLE_W-1:0] CLAMP_LOW  = -32'sd32767;

    typedef struct packed {
        logic [OPCODE_W-1:0]        opcode;
        logic [POS_W-1:0]           position;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_beat;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_byte;
    } t_out_beat;

endpackage

// ===== sv/saturating_pcm_mix_buffer_core.sv =====
// Path: an emitting item passes the read-modify-write stage register, then the output register,
// which offers its low byte and then its high byte, each held while the output is stalled.
// An emitting item leaves the stage only once the previous sample's high byte has left.
// Non-emitting items pass the read-modify-write stage one per cycle unless an emitting item waits.
// Reset clears all control state; the sum store keeps its contents and is not cleared.
module saturating_pcm_mix_buffer_core
    import spmb_pkg::*;
#(
    parameter int unsigned BUFFER_SAMPLES = BUFFER_SAMPLES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_beat o_out,
    input  logic      i_out_stall
);

    localparam int ADDR_W = (BUFFER_SAMPLES > 1) ? $clog2(BUFFER_SAMPLES) : 1;

    // Sum store, one 32-bit entry per buffer position.
    logic [SAMPLE_W-1:0] r_mix_sums [BUFFER_SAMPLES];
    logic [SAMPLE_W-1:0] r_rdata;

    // Read-modify-write stage.
    logic                r_s1_valid;
    logic [OPCODE_W-1:0] r_s1_opcode;
    logic [ADDR_W-1:0]   r_s1_addr;
    logic                r_s1_in_range;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic                r_s1_fwd;
    logic [SAMPLE_W-1:0] r_s1_fwd_data;

    // Output register holding one clamped sample as two byte beats.
    logic             r_out_valid;
    logic             r_out_hi;
    logic [PCM_W-1:0] r_pcm;

    logic                        in_accept;
    logic                        out_accept;
    logic [POS_W+ADDR_W-1:0]     pos_ext;
    logic [ADDR_W-1:0]           in_addr;
    logic                        in_range;
    logic                        out_free;
    logic                        s1_emit;
    logic                        s1_write;
    logic                        s1_advance;
    logic [SAMPLE_W-1:0]         s1_old;
    logic [SAMPLE_W-1:0]         s1_sum;
    logic [PCM_W-1:0]            s1_pcm;
    logic                        n_s1_fwd;
    logic                        n_out_valid;
    logic                        n_out_hi;

    // Input address decode and range check.
    always_comb begin
        pos_ext  = {{ADDR_W{1'b0}}, i_in.position};
        in_addr  = pos_ext[ADDR_W-1:0];
        in_range = ({{(DEPTH_CMP_W-POS_W){1'b0}}, i_in.position})
                   < DEPTH_CMP_W'(BUFFER_SAMPLES);
    end

    // Stage control: the output register frees up once the high byte leaves.
    always_comb begin
        out_accept = r_out_valid && !i_out_stall;
        out_free   = !r_out_valid || (r_out_hi && !i_out_stall);
        s1_emit    = r_s1_opcode inside {OP_ADD_EMIT, OP_WRITE_EMIT};
        s1_write   = r_s1_opcode inside {OP_WRITE, OP_WRITE_EMIT};
        s1_advance = r_s1_valid && (!s1_emit || out_free);
        o_in_stall = r_s1_valid && !s1_advance;
        in_accept  = i_in_valid && !o_in_stall;
    end

    // Modify: pick the old sum (forwarded when the previous item wrote the same entry).
    always_comb begin
        if (!r_s1_in_range) begin
            s1_old = '0;
        end else if (r_s1_fwd) begin
            s1_old = r_s1_fwd_data;
        end else begin
            s1_old = r_rdata;
        end
        s1_sum = s1_write ? r_s1_sample : s1_old + r_s1_sample;
    end

    // Clamp to the symmetric 16-bit range.
    always_comb begin
        if ($signed(s1_sum) > CLAMP_HIGH) begin
            s1_pcm = CLAMP_HIGH[PCM_W-1:0];
        end else if ($signed(s1_sum) < CLAMP_LOW) begin
            s1_pcm = CLAMP_LOW[PCM_W-1:0];
        end else begin
            s1_pcm = s1_sum[PCM_W-1:0];
        end
    end

    // The incoming item reads the store at the edge where the current one writes back,
    // so a hit on the same entry takes the new sum from the bypass.
    always_comb begin
        n_s1_fwd = s1_advance && r_s1_in_range && in_range && (in_addr == r_s1_addr);
    end

    // Memory read and write-back.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rdata <= r_mix_sums[in_addr];
        end
        if (s1_advance && r_s1_in_range) begin
            r_mix_sums[r_s1_addr] <= s1_sum;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_opcode   <= i_in.opcode;
            r_s1_addr     <= in_addr;
            r_s1_in_range <= in_range;
            r_s1_sample   <= i_in.sample;
            r_s1_fwd      <= n_s1_fwd;
            r_s1_fwd_data <= s1_sum;
        end
    end

    // Stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Output sequencing: low byte first, then high byte.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_hi    = r_out_hi;
        if (out_accept) begin
            if (r_out_hi) begin
                n_out_valid = 1'b0;
            end else begin
                n_out_hi = 1'b1;
            end
        end
        if (s1_advance && s1_emit) begin
            n_out_valid = 1'b1;
            n_out_hi    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_hi    <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_out_hi    <= n_out_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && s1_emit) begin
            r_pcm <= s1_pcm;
        end
    end

    // Output beat.
    always_comb begin
        o_out_valid     = r_out_valid;
        o_out.out_byte  = r_out_hi ? r_pcm[PCM_W-1:BYTE_W] : r_pcm[BYTE_W-1:0];
        o_out.last_byte = r_out_hi;
    end

endmodule
